// ===== src/cps_pkg.sv =====
`timescale 1ns / 1ps
// cps_pkg: shared types, widths and constants for the capture-period-to-speed block.
// No dependencies; imported by cps_arith_unit and capture_period_to_speed.
package cps_pkg;

    localparam int DEF_TIMESTAMP_BITS = 32;

    // register field widths
    localparam int CIRC_BITS   = 20;
    localparam int QT_BITS     = 16;
    localparam int UPQ_BITS    = 16;
    localparam int WIN_BITS    = 7;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = CIRC_BITS;

    // datapath widths
    localparam int SUM_BITS   = 40;
    localparam int SPEED_BITS = 20;
    localparam int NUM_BITS   = 34;   // circumference * 100 * edges
    localparam int MUL_BITS   = 16;   // multiplier width of the shared unit

    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};
    localparam int CENTI_SCALE = 100;

    // register reset values
    localparam logic [CIRC_BITS-1:0] CIRC_RESET = CIRC_BITS'(55264);
    localparam logic [QT_BITS-1:0]   QT_RESET   = QT_BITS'(10000);
    localparam logic [UPQ_BITS-1:0]  UPQ_RESET  = UPQ_BITS'(125);
    localparam logic [WIN_BITS-1:0]  WIN_RESET  = WIN_BITS'(10);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CIRC     = 2'd0,
        REG_QUANTUM  = 2'd1,
        REG_US_PER_Q = 2'd2,
        REG_WINDOW   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_DIV = 1'b0,
        OP_MUL = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } arith_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_DIV_PERIOD = 3'd1,
        ST_MUL_US     = 3'd2,
        ST_ACCUM      = 3'd3,
        ST_CHECK      = 3'd4,
        ST_MUL_NUM    = 3'd5,
        ST_DIV_SPEED  = 3'd6,
        ST_DELIVER    = 3'd7
    } state_t;

endpackage

// ===== src/cps_arith_unit.sv =====
`timescale 1ns / 1ps
// cps_arith_unit: shared shift/add unit, one bit per cycle.
// Restoring divide (DIV_BITS steps) or MSB-first shift-add multiply (MUL_BITS steps).
// Depends on cps_pkg.
module cps_arith_unit #(
    parameter int DIV_BITS = cps_pkg::NUM_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cps_pkg::arith_cmd_t          cmd,
    input  logic [DIV_BITS-1:0]          a_i,   // dividend, or multiplier in the top bits
    input  logic [cps_pkg::SUM_BITS-1:0] d_i,   // divisor, or multiplicand
    output cps_pkg::arith_sts_t          sts,
    output logic [DIV_BITS-1:0]          q_o,
    output logic [cps_pkg::SUM_BITS-1:0] r_o
);
    import cps_pkg::*;

    localparam int CW       = $clog2(DIV_BITS + 1);
    localparam int ADD_BITS = SUM_BITS + 2;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                ovf_reg, ovf_next;
    arith_op_t           op_reg, op_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] q_reg, q_next;
    logic [SUM_BITS-1:0] r_reg, r_next;
    logic [SUM_BITS-1:0] d_reg, d_next;

    logic [ADD_BITS-1:0] op_a, op_b, sum;
    logic                cin;
    logic                ge;

    // one adder serves both operations
    always_comb begin
        op_a = {1'b0, r_reg, (op_reg == OP_DIV) ? q_reg[DIV_BITS-1] : 1'b0};
        if (op_reg == OP_DIV) begin
            op_b = ~{2'b00, d_reg};
            cin  = 1'b1;
        end else begin
            op_b = q_reg[DIV_BITS-1] ? {2'b00, d_reg} : '0;
            cin  = 1'b0;
        end
        sum = op_a + op_b + ADD_BITS'(cin);
        ge  = ~sum[ADD_BITS-1];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (cmd.start && !busy_reg) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = (cmd.op == OP_DIV) ? CW'(DIV_BITS) : CW'(MUL_BITS);
            q_next    = a_i;
            r_next    = '0;
            d_next    = d_i;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            if (op_reg == OP_DIV) begin
                r_next = ge ? sum[SUM_BITS-1:0] : op_a[SUM_BITS-1:0];
                q_next = {q_reg[DIV_BITS-2:0], ge};
            end else begin
                r_next   = sum[SUM_BITS-1:0];
                ovf_next = ovf_reg | sum[ADD_BITS-1] | sum[ADD_BITS-2];
                q_next   = {q_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        ovf_reg <= ovf_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign q_o      = q_reg;
    assign r_o      = r_reg;

endmodule

// ===== src/capture_period_to_speed.sv =====
`timescale 1ns / 1ps
// capture_period_to_speed: top level, sequencer, configuration registers and output register.
// Depends on cps_pkg and cps_arith_unit.

// Wheel speed from rising-edge capture timestamps. Each request carries one timestamp; the
// first after reset only primes the previous-timestamp register. Every later request forms
// the period modulo 2^TIMESTAMP_BITS, truncates it to whole quanta (quantum_ticks, 0 acts as
// 1), scales by us_per_quantum into microseconds (saturating at 2^40-1) and adds it to a
// saturating 40-bit sum. Once window_edges periods (0 acts as 1) are summed, one result
// request gives floor(circumference_um * 100 * edges / sum) in cm/s, clipped at 1048575 with
// saturated set; a zero sum also gives 1048575 with saturated set. Every divide and multiply
// runs on one shared shift/add unit that handles one bit per cycle, and s_ready is high only
// while the sequencer is idle, so a new edge is taken only after the previous one is done.
// An edge that closes the window also waits until the output register is free. A finished
// result waits in the output register, and the next request is taken meanwhile.
// Configuration writes are taken every cycle and should be made while idle.
module capture_period_to_speed #(
    parameter int TIMESTAMP_BITS = cps_pkg::DEF_TIMESTAMP_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // capture requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [TIMESTAMP_BITS-1:0]         s_capture_time,
    // speed results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cps_pkg::SPEED_BITS-1:0]    m_speed_centi_mps,
    output logic                              m_saturated,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import cps_pkg::*;

    localparam int DW   = (TIMESTAMP_BITS > NUM_BITS) ? TIMESTAMP_BITS : NUM_BITS;
    localparam int WIDE = (DW > SUM_BITS) ? DW : SUM_BITS;

    // configuration registers
    logic [CIRC_BITS-1:0] circ_reg, circ_next;
    logic [QT_BITS-1:0]   qt_reg, qt_next;
    logic [UPQ_BITS-1:0]  upq_reg, upq_next;
    logic [WIN_BITS-1:0]  win_reg, win_next;

    // sequencer state
    state_t                    state_reg, state_next;
    logic [TIMESTAMP_BITS-1:0] last_reg, last_next;
    logic                      have_last_reg, have_last_next;
    logic [SUM_BITS-1:0]       sum_reg, sum_next;
    logic [WIN_BITS-1:0]       edge_reg, edge_next;
    logic [SUM_BITS-1:0]       us_reg, us_next;
    logic                      sat_pre_reg, sat_pre_next;
    logic [SPEED_BITS-1:0]     spd_reg, spd_next;
    logic                      sat_reg, sat_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [SPEED_BITS-1:0] m_speed_reg, m_speed_next;
    logic                  m_sat_reg, m_sat_next;

    // shared unit
    arith_cmd_t          unit_cmd;
    arith_sts_t          unit_sts;
    logic [DW-1:0]       unit_a;
    logic [SUM_BITS-1:0] unit_d;
    logic [DW-1:0]       unit_q;
    logic [SUM_BITS-1:0] unit_r;

    logic [TIMESTAMP_BITS-1:0] period;
    logic [WIDE-1:0]           quanta_wide;
    logic [SUM_BITS:0]         sum_ext;
    logic [WIN_BITS-1:0]       win_eff;
    logic [QT_BITS-1:0]        qt_eff;

    cps_arith_unit #(
        .DIV_BITS (DW)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (unit_cmd),
        .a_i     (unit_a),
        .d_i     (unit_d),
        .sts     (unit_sts),
        .q_o     (unit_q),
        .r_o     (unit_r)
    );

    // configuration port: always ready, drop writes past the register list
    assign cfg_ready = 1'b1;

    always_comb begin
        circ_next = circ_reg;
        qt_next   = qt_reg;
        upq_next  = upq_reg;
        win_next  = win_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_CIRC:     circ_next = cfg_data[CIRC_BITS-1:0];
                REG_QUANTUM:  qt_next   = cfg_data[QT_BITS-1:0];
                REG_US_PER_Q: upq_next  = cfg_data[UPQ_BITS-1:0];
                REG_WINDOW:   win_next  = cfg_data[WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign period      = s_capture_time - last_reg;
    assign quanta_wide = WIDE'(unit_q);
    assign sum_ext     = {1'b0, sum_reg} + {1'b0, us_reg};
    assign win_eff     = (win_reg == '0) ? WIN_BITS'(1) : win_reg;
    assign qt_eff      = (qt_reg == '0) ? QT_BITS'(1) : qt_reg;

    assign s_ready = (state_reg == ST_IDLE);

    // sequencer: next state, datapath loads and shared unit commands
    always_comb begin
        state_next     = state_reg;
        last_next      = last_reg;
        have_last_next = have_last_reg;
        sum_next       = sum_reg;
        edge_next      = edge_reg;
        us_next        = us_reg;
        sat_pre_next   = sat_pre_reg;
        spd_next       = spd_reg;
        sat_next       = sat_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_speed_next   = m_speed_reg;
        m_sat_next     = m_sat_reg;
        unit_cmd.start = 1'b0;
        unit_cmd.op    = OP_DIV;
        unit_a         = '0;
        unit_d         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next = s_capture_time;
                    if (have_last_reg) begin
                        // quanta = period / quantum_ticks
                        unit_cmd.start = 1'b1;
                        unit_cmd.op    = OP_DIV;
                        unit_a         = DW'(period);
                        unit_d         = SUM_BITS'(qt_eff);
                        state_next     = ST_DIV_PERIOD;
                    end else begin
                        have_last_next = 1'b1;
                    end
                end
            end
            ST_DIV_PERIOD: begin
                if (unit_sts.done) begin
                    // quanta beyond 40 bits saturate unless the scale is zero
                    sat_pre_next   = (upq_reg != '0) && ((quanta_wide >> SUM_BITS) != '0);
                    unit_cmd.start = 1'b1;
                    unit_cmd.op    = OP_MUL;
                    unit_a         = {MUL_BITS'(upq_reg), {(DW-MUL_BITS){1'b0}}};
                    unit_d         = quanta_wide[SUM_BITS-1:0];
                    state_next     = ST_MUL_US;
                end
            end
            ST_MUL_US: begin
                if (unit_sts.done) begin
                    us_next    = (sat_pre_reg || unit_sts.ovf) ? SUM_MAX : unit_r;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                sum_next   = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
                edge_next  = edge_reg + WIN_BITS'(1);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (edge_reg < win_eff) begin
                    state_next = ST_IDLE;
                end else begin
                    // numerator = circumference * 100 * edges
                    unit_cmd.start = 1'b1;
                    unit_cmd.op    = OP_MUL;
                    unit_a         = {MUL_BITS'(edge_reg), {(DW-MUL_BITS){1'b0}}};
                    unit_d         = SUM_BITS'(circ_reg) * SUM_BITS'(CENTI_SCALE);
                    state_next     = ST_MUL_NUM;
                end
            end
            ST_MUL_NUM: begin
                if (unit_sts.done) begin
                    if (sum_reg == '0) begin
                        spd_next   = SPEED_MAX;
                        sat_next   = 1'b1;
                        state_next = ST_DELIVER;
                    end else begin
                        unit_cmd.start = 1'b1;
                        unit_cmd.op    = OP_DIV;
                        unit_a         = DW'(unit_r);
                        unit_d         = sum_reg;
                        state_next     = ST_DIV_SPEED;
                    end
                end
            end
            ST_DIV_SPEED: begin
                if (unit_sts.done) begin
                    if (unit_q > DW'(SPEED_MAX)) begin
                        spd_next = SPEED_MAX;
                        sat_next = 1'b1;
                    end else begin
                        spd_next = unit_q[SPEED_BITS-1:0];
                        sat_next = 1'b0;
                    end
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                // hold until the output register is free, then clear the window
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_speed_next = spd_reg;
                    m_sat_next   = sat_reg;
                    sum_next     = '0;
                    edge_next    = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            have_last_reg <= 1'b0;
            sum_reg       <= '0;
            edge_reg      <= '0;
            m_valid_reg   <= 1'b0;
            circ_reg      <= CIRC_RESET;
            qt_reg        <= QT_RESET;
            upq_reg       <= UPQ_RESET;
            win_reg       <= WIN_RESET;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            have_last_reg <= have_last_next;
            sum_reg       <= sum_next;
            edge_reg      <= edge_next;
            m_valid_reg   <= m_valid_next;
            circ_reg      <= circ_next;
            qt_reg        <= qt_next;
            upq_reg       <= upq_next;
            win_reg       <= win_next;
        end
        us_reg      <= us_next;
        sat_pre_reg <= sat_pre_next;
        spd_reg     <= spd_next;
        sat_reg     <= sat_next;
        m_speed_reg <= m_speed_next;
        m_sat_reg   <= m_sat_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_speed_centi_mps = m_speed_reg;
    assign m_saturated       = m_sat_reg;

`ifndef SYNTH
    // a capture is only taken while the shared unit is free
    a_accept_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !unit_sts.busy)
        else $error("capture accepted while shared unit busy");

    // the shared unit only finishes in a state that waits for it
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_sts.done |-> (state_reg == ST_DIV_PERIOD || state_reg == ST_MUL_US ||
                           state_reg == ST_MUL_NUM || state_reg == ST_DIV_SPEED))
        else $error("shared unit finished in unexpected state");

    // a pending result holds the sequencer
    a_deliver_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DELIVER && m_valid_reg && !m_ready |=> state_reg == ST_DELIVER)
        else $error("result overwritten before taken");

    // delivering a result clears the window
    a_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DELIVER && (!m_valid_reg || m_ready) |=>
            sum_reg == '0 && edge_reg == '0)
        else $error("window not cleared after result");

    // a saturated result always carries the maximum speed
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_sat_reg |-> m_speed_reg == SPEED_MAX)
        else $error("saturated result below maximum");
`endif

endmodule
